@@ design/cdfir_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdfir_pkg: shared definitions of the depthwise causal FIR filter
// Constants, field widths, operation and register codes, and the transaction
// layout that travels from the front part to the arithmetic back part.
// ----------------------------------------------------------------------------
package cdfir_pkg;

  // Fixed formats of the item fields
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned MAX_TAPS    = 8;
  localparam int unsigned CHANNELS    = 16;
  localparam int unsigned CH_W        = 4;
  localparam int unsigned TAP_W       = 3;
  localparam int unsigned OP_W        = 2;

  // Configuration port
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned CFG_DATA_W      = 4;
  localparam int unsigned CNT_W           = 4;
  localparam int unsigned TAP_COUNT_RESET = 4;

  // Arithmetic: Q1.15 operands, Q2.30 products, Q9.15 result
  localparam int unsigned OUT_BITS   = 24;
  localparam int unsigned OUT_FRAC   = 15;
  localparam int unsigned FRAC_BITS  = SAMPLE_BITS - 1;
  localparam int unsigned RND_SHIFT  = 2 * FRAC_BITS - OUT_FRAC;
  localparam int unsigned PROD_W     = 2 * SAMPLE_BITS;
  localparam int unsigned ACC_W      = PROD_W + $clog2(MAX_TAPS + 1);

  // Default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE = 2'd0,
    OP_WEIGHT = 2'd1,
    OP_BIAS   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    BIAS_NONE = 2'd0,
    BIAS_ADD  = 2'd1,
    BIAS_MUL  = 2'd2
  } bias_sel_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TAP_COUNT = 2'd0,
    CFG_TAP_ORDER = 2'd1,
    CFG_BIAS_SEL  = 2'd2
  } cfg_idx_e;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef sample_t [MAX_TAPS-1:0] row_t;

  typedef struct packed {
    logic [CNT_W-1:0] tap_count;
    logic             tap_order;
    logic [1:0]       bias_sel;
  } cfg_t;

  // One sample transaction, with everything the arithmetic needs
  typedef struct packed {
    logic [CH_W-1:0] channel;
    sample_t         sample;
    row_t            history;
    row_t            weights;
    sample_t         bias;
  } q_item_t;

endpackage

@@ design/cdfir_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdfir_front: input stage of the depthwise causal FIR filter
// Accepts transactions, applies weight and bias writes, shifts samples into
// the per-channel delay lines and queues sample work for the back part.
// ----------------------------------------------------------------------------
module cdfir_front import cdfir_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [OP_W-1:0]        operation_i,
  input  logic [CH_W-1:0]        channel_i,
  input  logic [TAP_W-1:0]       tap_i,
  input  logic signed [SAMPLE_BITS-1:0] data_value_i,
  input  logic                   sequence_start_i,
  input  logic                   q_full_i,
  output logic                   push_o,
  output q_item_t                push_item_o
);

  row_t    hist_q [CHANNELS];
  row_t    wt_q   [CHANNELS];
  sample_t bias_q [CHANNELS];

  logic accept;
  logic is_sample;
  logic is_weight;
  logic is_bias;
  row_t row_old;
  row_t row_new;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;

  always_comb begin
    is_sample = 1'b0;
    is_weight = 1'b0;
    is_bias   = 1'b0;
    case (op_e'(operation_i))
      OP_SAMPLE: is_sample = 1'b1;
      OP_WEIGHT: is_weight = 1'b1;
      OP_BIAS:   is_bias   = 1'b1;
      default: ;
    endcase
  end

  // Shift the new sample in; drop the old history at time zero
  always_comb begin
    row_old    = hist_q[channel_i];
    row_new[0] = data_value_i;
    for (int t = 1; t < MAX_TAPS; t++) begin
      row_new[t] = sequence_start_i ? '0 : row_old[t-1];
    end
  end

  assign push_o              = accept & is_sample;
  assign push_item_o.channel = channel_i;
  assign push_item_o.sample  = data_value_i;
  assign push_item_o.history = row_new;
  assign push_item_o.weights = wt_q[channel_i];
  assign push_item_o.bias    = bias_q[channel_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        hist_q[c] <= '0;
      end
    end else if (push_o) begin
      hist_q[channel_i] <= row_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_weight) begin
      wt_q[channel_i][tap_i] <= data_value_i;
    end
    if (accept && is_bias) begin
      bias_q[channel_i] <= data_value_i;
    end
  end

endmodule

@@ design/cdfir_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdfir_queue: short FIFO between front and back parts
// Holds queued sample transactions so that either side can stall alone.
// ----------------------------------------------------------------------------
module cdfir_queue import cdfir_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  q_item_t item_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    valid_o,
  output q_item_t item_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_QW = $clog2(DEPTH + 1);

  q_item_t           mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_QW-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_QW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> !pop_i)
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> count_q <= CNT_QW'(DEPTH) && count_q != '0)
    else $error("queue fill count out of range");
`endif

endmodule

@@ design/cdfir_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdfir_back: arithmetic pipeline of the depthwise causal FIR filter
// Multiplies all taps in parallel, sums them in a registered tree, rounds
// to Q9.15 and saturates into the output register.
// ----------------------------------------------------------------------------
module cdfir_back import cdfir_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cfg_t                       cfg_i,
  input  logic                       item_valid_i,
  input  q_item_t                    item_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [CH_W-1:0]            out_channel_o,
  output logic signed [OUT_BITS-1:0] filtered_value_o,
  output logic                       saturated_o
);

  localparam int unsigned PAIRS = MAX_TAPS / 2;
  localparam int unsigned QUADS = MAX_TAPS / 4;
  localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(1) << (RND_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] RES_MAX = ACC_W'((1 << (OUT_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0] RES_MIN = ~RES_MAX;

  logic en1, en2, en3, en4;

  // Stage 1: products
  logic                     v1_q;
  logic [CH_W-1:0]          ch1_q;
  logic signed [PROD_W-1:0] prod_d  [MAX_TAPS];
  logic signed [PROD_W-1:0] prod1_q [MAX_TAPS];
  logic signed [PROD_W-1:0] bterm_d, bterm1_q;

  // Stage 2: pair sums
  logic                     v2_q;
  logic [CH_W-1:0]          ch2_q;
  logic signed [PROD_W:0]   sum2_d [PAIRS];
  logic signed [PROD_W:0]   sum2_q [PAIRS];
  logic signed [PROD_W-1:0] bterm2_q;

  // Stage 3: quad sums
  logic                     v3_q;
  logic [CH_W-1:0]          ch3_q;
  logic signed [PROD_W+1:0] sum3_d [QUADS];
  logic signed [PROD_W+1:0] sum3_q [QUADS];
  logic signed [PROD_W-1:0] bterm3_q;

  // Stage 4: output register
  logic                       out_valid_q;
  logic [CH_W-1:0]            out_channel_q;
  logic signed [OUT_BITS-1:0] value_q, value_d;
  logic                       sat_q, sat_d;
  logic signed [ACC_W-1:0]    acc, rnd, shifted;

  logic [CNT_W-1:0] k_eff;

  // Advance a stage when it is empty or the next one advances
  assign en4   = ~out_valid_q | ~out_stall_i;
  assign en3   = ~v3_q | en4;
  assign en2   = ~v2_q | en3;
  assign en1   = ~v1_q | en2;
  assign pop_o = item_valid_i & en1;

  assign k_eff = (cfg_i.tap_count > CNT_W'(MAX_TAPS)) ? CNT_W'(MAX_TAPS) : cfg_i.tap_count;

  for (genvar t = 0; t < MAX_TAPS; t++) begin : g_tap
    logic [CNT_W-1:0]         rev_idx;
    logic [TAP_W-1:0]         hist_idx;
    logic                     used;
    logic signed [SAMPLE_BITS-1:0] w_s, h_s;
    logic signed [PROD_W-1:0] mult;

    assign rev_idx  = k_eff - CNT_W'(t) - CNT_W'(1);
    assign hist_idx = cfg_i.tap_order ? TAP_W'(t) : rev_idx[TAP_W-1:0];
    assign used     = (CNT_W'(t) < k_eff);
    assign w_s      = item_i.weights[t];
    assign h_s      = item_i.history[hist_idx];
    assign mult     = w_s * h_s;
    assign prod_d[t] = used ? mult : '0;
  end

  always_comb begin
    logic signed [SAMPLE_BITS-1:0] b_s, x_s;
    logic signed [PROD_W-1:0]      bx;
    b_s = item_i.bias;
    x_s = item_i.sample;
    bx  = b_s * x_s;
    case (bias_sel_e'(cfg_i.bias_sel))
      BIAS_ADD: bterm_d = $signed({b_s, FRAC_BITS'(0)});
      BIAS_MUL: bterm_d = bx;
      default:  bterm_d = '0;
    endcase
  end

  for (genvar p = 0; p < PAIRS; p++) begin : g_pair
    assign sum2_d[p] = prod1_q[2*p] + prod1_q[2*p+1];
  end

  for (genvar q = 0; q < QUADS; q++) begin : g_quad
    assign sum3_d[q] = sum2_q[2*q] + sum2_q[2*q+1];
  end

  // Round half up, then clip to Q9.15
  always_comb begin
    acc     = sum3_q[0] + sum3_q[1] + bterm3_q;
    rnd     = acc + HALF;
    shifted = rnd >>> RND_SHIFT;
    sat_d   = 1'b0;
    if (shifted > RES_MAX) begin
      value_d = RES_MAX[OUT_BITS-1:0];
      sat_d   = 1'b1;
    end else if (shifted < RES_MIN) begin
      value_d = RES_MIN[OUT_BITS-1:0];
      sat_d   = 1'b1;
    end else begin
      value_d = shifted[OUT_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1) v1_q <= item_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) out_valid_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ch1_q    <= item_i.channel;
      prod1_q  <= prod_d;
      bterm1_q <= bterm_d;
    end
    if (en2 && v1_q) begin
      ch2_q    <= ch1_q;
      sum2_q   <= sum2_d;
      bterm2_q <= bterm1_q;
    end
    if (en3 && v2_q) begin
      ch3_q    <= ch2_q;
      sum3_q   <= sum3_d;
      bterm3_q <= bterm2_q;
    end
    if (en4 && v3_q) begin
      out_channel_q <= ch3_q;
      value_q       <= value_d;
      sat_q         <= sat_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_channel_o    = out_channel_q;
  assign filtered_value_o = value_q;
  assign saturated_o      = sat_q;

`ifndef SYNTHESIS
  a_pop_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> v1_q)
    else $error("popped transaction lost before first stage");
  a_s3_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && out_valid_q && out_stall_i |=> v3_q && out_valid_q)
    else $error("pipeline dropped a transaction while output stalled");
`endif

endmodule

@@ design/causal_depthwise_fir_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// causal_depthwise_fir_filter: per-channel causal FIR filter
// Q1.15 in, Q9.15 out; configuration registers, front part, queue and back.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): one transaction per cycle when
//   not stalled. A transaction writes a tap weight, writes a channel bias or
//   carries one sample of one channel; only samples produce a result.
//   Output channel (out_valid_o / out_stall_i): one result per sample, in
//   input order, holding still while out_stall_i is high.
//   Configuration channel (cfg_valid_i / cfg_ready_o): always ready; write
//   tap_count, tap_order and bias selection only while the filter is idle.
// Path: an accepted sample goes through the queue, products, pair sums, and
//   quad sums plus rounding into the output register. Throughput: one
//   transaction per cycle when not stalled, set by the eight parallel tap
//   multipliers feeding a registered adder tree.
// Stalls: the output register and pipeline hold; the queue then fills and
//   in_stall_o rises once it holds QUEUE_DEPTH_P transactions.
// Reset: delay lines clear to zero, the queue and pipeline empty, registers
//   return to tap_count 4, cross-correlation order, no bias. Weights and
//   biases must be written before use.
// ----------------------------------------------------------------------------
module causal_depthwise_fir_filter import cdfir_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Input transactions
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [OP_W-1:0]            operation_i,
  input  logic [CH_W-1:0]            channel_i,
  input  logic [TAP_W-1:0]           tap_i,
  input  logic signed [SAMPLE_BITS-1:0] data_value_i,
  input  logic                       sequence_start_i,
  // Configuration writes
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  // Results
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [CH_W-1:0]            out_channel_o,
  output logic signed [OUT_BITS-1:0] filtered_value_o,
  output logic                       saturated_o
);

  cfg_t    cfg_q, cfg_d;
  logic    q_full;
  logic    push;
  q_item_t push_item;
  logic    pop;
  logic    q_valid;
  q_item_t q_item;

  // Configuration registers; writes to an unknown index are dropped
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_TAP_COUNT: cfg_d.tap_count = cfg_data_i[CNT_W-1:0];
        CFG_TAP_ORDER: cfg_d.tap_order = cfg_data_i[0];
        CFG_BIAS_SEL:  cfg_d.bias_sel  = cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tap_count <= CNT_W'(TAP_COUNT_RESET);
      cfg_q.tap_order <= 1'b0;
      cfg_q.bias_sel  <= BIAS_NONE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: classify transactions, update tables and delay lines
  cdfir_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .channel_i        (channel_i),
    .tap_i            (tap_i),
    .data_value_i     (data_value_i),
    .sequence_start_i (sequence_start_i),
    .q_full_i         (q_full),
    .push_o           (push),
    .push_item_o      (push_item)
  );

  // Decouple front from back
  cdfir_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  // Back: multiply, sum, round, saturate
  cdfir_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .item_valid_i     (q_valid),
    .item_i           (q_item),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_channel_o    (out_channel_o),
    .filtered_value_o (filtered_value_o),
    .saturated_o      (saturated_o)
  );

endmodule

@@ verif/causal_depthwise_fir_filter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// causal_depthwise_fir_filter_tb: self-checking bench of the per-channel FIR
// A queue of transactions feeds a clocked driver; a clocked monitor checks
// each filtered sample against a bit-exact Q1.15 / Q9.15 shadow of the filter
// that the driver updates on every accepted transaction. The run goes through
// a directed opening and then register settings with random time-major
// sequences, random idling on both sides and one long output hold.
// ----------------------------------------------------------------------------
module causal_depthwise_fir_filter_tb;
  import cdfir_pkg::*;

  localparam int          HALF_PERIOD   = 4;
  localparam int          RESET_CYCLES  = 9;
  localparam int          SETTLE_CYCLES = 8;       // four-stage pipeline plus margin
  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          PHASE_ITEMS   = 140;
  localparam int          SQUEEZE_HOLD  = 150;     // long output hold, in cycles
  localparam int          MAX_BURST     = 13;
  localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;  // opcode the filter drops
  localparam logic [1:0]      BIAS_UNUSED = 2'd3;  // bias selection that acts as none
  localparam longint      OUT_MAX = (longint'(1) << (OUT_BITS - 1)) - 1;
  localparam longint      OUT_MIN = -(longint'(1) << (OUT_BITS - 1));

  // One input transaction as the driver presents it
  typedef struct {
    logic [OP_W-1:0]  op;
    logic [CH_W-1:0]  ch;
    logic [TAP_W-1:0] tap;
    sample_t          data;
    logic             start;
  } fir_item_t;

  // One filtered sample as the monitor expects it
  typedef struct {
    logic [CH_W-1:0]            ch;
    logic signed [OUT_BITS-1:0] value;
    logic                       sat;
  } filt_result_t;

  logic                          clk_i            = 1'b0;
  logic                          rst_ni           = 1'b0;
  logic                          in_valid_i       = 1'b0;
  logic                          in_stall_o;
  logic [OP_W-1:0]               operation_i      = '0;
  logic [CH_W-1:0]               channel_i        = '0;
  logic [TAP_W-1:0]              tap_i            = '0;
  logic signed [SAMPLE_BITS-1:0] data_value_i     = '0;
  logic                          sequence_start_i = 1'b0;
  logic                          cfg_valid_i      = 1'b0;
  logic                          cfg_ready_o;
  logic [CFG_IDX_W-1:0]          cfg_index_i      = '0;
  logic [CFG_DATA_W-1:0]         cfg_data_i       = '0;
  logic                          out_valid_o;
  logic                          out_stall_i      = 1'b0;
  logic [CH_W-1:0]               out_channel_o;
  logic signed [OUT_BITS-1:0]    filtered_value_o;
  logic                          saturated_o;

  causal_depthwise_fir_filter DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .channel_i        (channel_i),
    .tap_i            (tap_i),
    .data_value_i     (data_value_i),
    .sequence_start_i (sequence_start_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_channel_o    (out_channel_o),
    .filtered_value_o (filtered_value_o),
    .saturated_o      (saturated_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Transactions waiting to be driven, and filtered samples waiting to arrive
  fir_item_t    stim_items[$];
  filt_result_t filtered_due[$];

  // Shadow of the filter state, updated at acceptance; delay lines start clear
  sample_t    delay_line [CHANNELS][MAX_TAPS] = '{default: '0};
  sample_t    tap_w      [CHANNELS][MAX_TAPS];
  sample_t    ch_bias    [CHANNELS];
  logic [3:0] cfg_taps  = CNT_W'(TAP_COUNT_RESET);
  logic       cfg_order = 1'b0;
  logic [1:0] cfg_bias  = BIAS_NONE;

  // Generator view of which weights and biases hold a written value; a sample
  // must never read an entry that was never written
  bit w_ready [CHANNELS][MAX_TAPS];
  bit b_ready [CHANNELS];

  // Idling and hold control
  int idle_rate     = 0;  // percent chance of a burst after each step, 0 = none
  int pressure_req  = 0;
  int pressure_seen = 0;
  int send_gap      = 0;
  int stall_left    = 0;

  // Bookkeeping
  int        fail_count     = 0;
  int        cycle_count    = 0;
  int        phase_items    = 0;
  int        accepted_items = 0;
  int        weight_writes  = 0;
  int        bias_writes    = 0;
  int        dropped_ops    = 0;
  int        samples_seen   = 0;
  int        sat_expected   = 0;
  int        settings_run   = 0;
  fir_item_t    cur_item;
  filt_result_t due_r;

  // --------------------------------------------------------------------------
  // Shadow filter: apply one accepted transaction and queue its result
  // --------------------------------------------------------------------------
  function automatic void filter_step(input fir_item_t it);
    longint       acc;
    longint       res;
    int           k;
    int           d;
    int           t;
    filt_result_t r;
    if (it.op == OP_WEIGHT) begin
      tap_w[it.ch][it.tap] = it.data;
      weight_writes++;
      return;
    end
    if (it.op == OP_BIAS) begin
      ch_bias[it.ch] = it.data;
      bias_writes++;
      return;
    end
    if (it.op != OP_SAMPLE) begin
      dropped_ops++;
      return;
    end
    // Clear the line at time zero, then shift the new sample in
    if (it.start) begin
      for (t = 0; t < MAX_TAPS; t++) delay_line[it.ch][t] = '0;
    end
    for (t = MAX_TAPS - 1; t > 0; t--) delay_line[it.ch][t] = delay_line[it.ch][t - 1];
    delay_line[it.ch][0] = it.data;

    k   = (cfg_taps > MAX_TAPS) ? MAX_TAPS : int'(cfg_taps);
    acc = 0;
    if (cfg_bias == BIAS_ADD) acc = longint'(ch_bias[it.ch]) <<< FRAC_BITS;
    for (t = 0; t < k; t++) begin
      d   = cfg_order ? t : k - 1 - t;
      acc = acc + longint'(tap_w[it.ch][t]) * longint'(delay_line[it.ch][d]);
    end
    if (cfg_bias == BIAS_MUL) acc = acc + longint'(ch_bias[it.ch]) * longint'(it.data);

    // Round half up into Q9.15, then clip
    res   = (acc + (longint'(1) << (RND_SHIFT - 1))) >>> RND_SHIFT;
    r.sat = 1'b0;
    if (res > OUT_MAX) begin
      res   = OUT_MAX;
      r.sat = 1'b1;
    end else if (res < OUT_MIN) begin
      res   = OUT_MIN;
      r.sat = 1'b1;
    end
    if (r.sat) sat_expected++;
    r.ch    = it.ch;
    r.value = res[OUT_BITS-1:0];
    filtered_due.push_back(r);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: hold the payload while stalled, otherwise idle or present the next
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i       <= 1'b0;
      operation_i      <= '0;
      channel_i        <= '0;
      tap_i            <= '0;
      data_value_i     <= '0;
      sequence_start_i <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        filter_step(cur_item);
        accepted_items++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (stim_items.size() > 0) begin
          cur_item = stim_items.pop_front();
          in_valid_i       <= 1'b1;
          operation_i      <= cur_item.op;
          channel_i        <= cur_item.ch;
          tap_i            <= cur_item.tap;
          data_value_i     <= cur_item.data;
          sequence_start_i <= cur_item.start;
          // Schedule a gap after this transaction now and then
          if (idle_rate != 0 && $urandom_range(0, 99) < idle_rate)
            send_gap = $urandom_range(1, MAX_BURST);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each accepted result, then decide the next stall
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (filtered_due.size() == 0) begin
          $error("unexpected result: out_channel %0d filtered_value %0d",
                 out_channel_o, filtered_value_o);
          fail_count++;
        end else begin
          due_r = filtered_due.pop_front();
          samples_seen++;
          if (out_channel_o !== due_r.ch) begin
            $error("out_channel: expected %0d, actual %0d", due_r.ch, out_channel_o);
            fail_count++;
          end
          if (filtered_value_o !== due_r.value) begin
            $error("filtered_value: expected %0d, actual %0d", due_r.value,
                   filtered_value_o);
            fail_count++;
          end
          if (saturated_o !== due_r.sat) begin
            $error("saturated: expected %0d, actual %0d", due_r.sat, saturated_o);
            fail_count++;
          end
        end
      end
      // A new hold request wins over random stalls: hold long enough that the
      // queue fills and the filter stalls its input
      if (pressure_req != pressure_seen) begin
        pressure_seen = pressure_req;
        stall_left    = SQUEEZE_HOLD;
      end else if (stall_left == 0 && idle_rate != 0 && $urandom_range(0, 99) < idle_rate) begin
        stall_left = $urandom_range(1, MAX_BURST);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("cycle limit of %0d reached with %0d results outstanding", CYCLE_LIMIT,
               filtered_due.size());
      $display("causal_depthwise_fir_filter_tb failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Q1.15 value, biased toward the extremes and the values around zero
  function automatic sample_t rand_q15();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      3:       return 16'shFFFF;
      default: return sample_t'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic push_item(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                           input logic [TAP_W-1:0] tap, input sample_t data,
                           input logic start);
    fir_item_t it;
    it.op    = op;
    it.ch    = ch;
    it.tap   = tap;
    it.data  = data;
    it.start = start;
    stim_items.push_back(it);
    if (op == OP_WEIGHT) w_ready[ch][tap] = 1'b1;
    if (op == OP_BIAS) b_ready[ch] = 1'b1;
    if (op != OP_UNUSED) phase_items++;
  endtask

  // Queue a sample, preceded by whatever weight or bias writes it would read
  task automatic push_sample(input logic [CH_W-1:0] ch, input sample_t data,
                             input logic start);
    int k;
    int t;
    k = (cfg_taps > MAX_TAPS) ? MAX_TAPS : int'(cfg_taps);
    for (t = 0; t < k; t++) begin
      if (!w_ready[ch][t])
        push_item(OP_WEIGHT, ch, TAP_W'(t), rand_q15(), 1'($urandom_range(0, 1)));
    end
    if ((cfg_bias == BIAS_ADD || cfg_bias == BIAS_MUL) && !b_ready[ch])
      push_item(OP_BIAS, ch, TAP_W'($urandom_range(0, 7)), rand_q15(),
                1'($urandom_range(0, 1)));
    push_item(OP_SAMPLE, ch, TAP_W'($urandom_range(0, 7)), data, start);
  endtask

  // Wait until every transaction is in and every result is out, then let
  // the pipeline drain anything that produces no result
  task automatic wait_idle();
    do @(posedge clk_i);
    while (stim_items.size() != 0 || in_valid_i || filtered_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_TAP_COUNT: cfg_taps  = val;
      CFG_TAP_ORDER: cfg_order = val[0];
      CFG_BIAS_SEL:  cfg_bias  = val[1:0];
      default: ;
    endcase
  endtask

  // One register setting followed by random traffic. Most of it is time-major
  // sequences: a run of time steps over a few neighboring channels, each
  // sequence opening at time zero. The rest is loose writes, stray samples and
  // dropped opcodes.
  task automatic run_phase(input logic [3:0] taps, input logic [3:0] order,
                           input logic [3:0] bmode, input int rate, input bit squeeze);
    int nch;
    int base;
    int len;
    int s;
    int c;
    write_reg(CFG_TAP_COUNT, taps);
    write_reg(CFG_TAP_ORDER, order);
    write_reg(CFG_BIAS_SEL, bmode);
    settings_run++;
    phase_items = 0;
    while (phase_items < PHASE_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        nch  = $urandom_range(1, 4);
        base = $urandom_range(0, CHANNELS - 1);
        len  = $urandom_range(1, 12);
        for (s = 0; s < len; s++)
          for (c = 0; c < nch; c++)
            push_sample(CH_W'(base + c), rand_q15(), s == 0);
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3:
            push_sample(CH_W'($urandom_range(0, 15)), rand_q15(), 1'($urandom_range(0, 1)));
          4, 5, 6:
            push_item(OP_WEIGHT, CH_W'($urandom_range(0, 15)), TAP_W'($urandom_range(0, 7)),
                      rand_q15(), 1'($urandom_range(0, 1)));
          7:
            push_item(OP_BIAS, CH_W'($urandom_range(0, 15)), TAP_W'($urandom_range(0, 7)),
                      rand_q15(), 1'($urandom_range(0, 1)));
          default:
            push_item(OP_UNUSED, CH_W'($urandom_range(0, 15)), TAP_W'($urandom_range(0, 7)),
                      rand_q15(), 1'($urandom_range(0, 1)));
        endcase
      end
    end
    idle_rate = rate;
    // Hold the output long while the driver keeps offering transactions
    if (squeeze) pressure_req++;
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening at the reset setting: four taps, cross-correlation
    // order, no bias. Load extreme weights, then walk samples through them.
    settings_run = 1;
    push_item(OP_WEIGHT, 4'd0, 3'd0, 16'sh7FFF, 1'b0);
    push_item(OP_WEIGHT, 4'd0, 3'd1, 16'sh8000, 1'b0);
    push_item(OP_WEIGHT, 4'd0, 3'd2, 16'sh0001, 1'b0);
    push_item(OP_WEIGHT, 4'd0, 3'd3, 16'shFFFF, 1'b0);
    for (int t = 0; t < 4; t++) push_item(OP_WEIGHT, 4'd15, TAP_W'(t), 16'sh8000, 1'b0);
    // Time-zero flag on writes must be ignored; top tap index too
    push_item(OP_WEIGHT, 4'd15, 3'd7, 16'sh7FFF, 1'b1);
    push_item(OP_BIAS, 4'd0, 3'd0, 16'sh8000, 1'b1);
    push_item(OP_BIAS, 4'd15, 3'd7, 16'sh7FFF, 1'b0);
    push_sample(4'd0, 16'sh7FFF, 1'b1);
    push_sample(4'd0, 16'sh8000, 1'b0);
    push_sample(4'd0, 16'sh0000, 1'b0);
    push_sample(4'd0, 16'shFFFF, 1'b0);
    push_sample(4'd0, 16'sh0001, 1'b0);
    // Most negative samples against most negative weights: largest output
    push_sample(4'd15, 16'sh8000, 1'b1);
    for (int s = 0; s < 3; s++) push_sample(4'd15, 16'sh8000, 1'b0);
    // A dropped opcode must not disturb the history of channel 0
    push_item(OP_UNUSED, 4'd15, 3'd7, 16'shFFFF, 1'b1);
    push_sample(4'd0, 16'sh3039, 1'b0);
    // Restart channel 0 in the middle of its stream
    push_sample(4'd0, 16'sh3039, 1'b1);
    idle_rate = 0;
    wait_idle();

    // Register settings: full and zero taps, counts above the tap limit,
    // both tap orders and every bias selection including the unused code
    run_phase(4'd8, 4'd1, BIAS_ADD, 5, 1'b1);
    run_phase(4'd0, 4'd0, BIAS_ADD, 10, 1'b0);
    run_phase(4'd15, 4'd1, BIAS_MUL, 25, 1'b0);
    run_phase(4'd1, 4'd0, BIAS_MUL, 0, 1'b0);
    run_phase(4'd9, 4'd0, BIAS_UNUSED, 10, 1'b0);
    run_phase(4'd0, 4'd1, BIAS_NONE, 10, 1'b0);
    run_phase(4'($urandom_range(0, 15)), 4'($urandom_range(0, 1)),
              4'($urandom_range(0, 3)), 15, 1'b0);
    run_phase(4'd5, 4'd1, BIAS_ADD, 10, 1'b0);
    run_phase(4'd7, 4'd0, BIAS_MUL, 10, 1'b0);
    // Finish at full rate on both sides
    run_phase(4'd8, 4'd0, BIAS_ADD, 0, 1'b0);

    $display("%0d transactions accepted: %0d weight writes, %0d bias writes, %0d dropped opcodes",
             accepted_items, weight_writes, bias_writes, dropped_ops);
    $display("%0d filtered samples checked over %0d register settings, %0d expected clipped",
             samples_seen, settings_run, sat_expected);
    if (fail_count == 0) begin
      $display("causal_depthwise_fir_filter_tb passed");
    end else begin
      $display("causal_depthwise_fir_filter_tb failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/cdfir_pkg.sv
design/cdfir_front.sv
design/cdfir_queue.sv
design/cdfir_back.sv
design/causal_depthwise_fir_filter.sv
verif/causal_depthwise_fir_filter_tb.sv
